[design/id_hash_hue_to_rgb_core_assert.svh]
// Assertion macros for the id hash hue to rgb core.
`ifndef ID_HASH_HUE_TO_RGB_CORE_ASSERT_SVH
`define ID_HASH_HUE_TO_RGB_CORE_ASSERT_SVH

// Checked only while out of reset.
`define IDHR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IDHR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/idhr_pkg.sv]
// Shared constants and types for the id hash hue to rgb core.
`timescale 1ns / 1ps

package idhr_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int HASH_BITS        = 32;
    localparam int HUE_BITS         = 16;
    localparam int FRAC_BITS        = 16;
    localparam int SECT_BITS        = 3;
    localparam int CFG_ADDR_BITS    = 1;
    localparam int CFG_RESET_VAL    = 230;

    localparam logic [HASH_BITS-1:0] HASH_MUL = 32'h9E3779B9;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SATURATION = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BRIGHTNESS = 1'd1;

    typedef enum logic [SECT_BITS-1:0] {
        SECT_RED_TO_YEL = 3'd0,
        SECT_YEL_TO_GRN = 3'd1,
        SECT_GRN_TO_CYN = 3'd2,
        SECT_CYN_TO_BLU = 3'd3,
        SECT_BLU_TO_MAG = 3'd4,
        SECT_MAG_TO_RED = 3'd5
    } sector_t;

endpackage

[design/id_hash_hue_to_rgb_core.sv]
// Usage:
// Turns a 32-bit identifier into an RGB color. The s_ channel carries the
// identifier; the hue is its Fibonacci hash, converted by the six-sector HSV
// rule with the saturation and brightness registers.
// The m_ channel carries one color per request (red, green, blue).
// Registers are written through cfg_wr_en / cfg_addr / cfg_wdata; the user must write them only while
// no request is in flight, which the block does not enforce; index 0 is saturation, 1 is brightness.
// Five register stages lie between acceptance and m_tvalid (hash multiply, sector,
// ramp multiply, offset add, divide by full scale).
// Throughput: one request per cycle while m_tready is high; the five register stages, each with
// its own valid bit, set the rate and latency.
// When the receiver stalls, results stay in their stages and empty stages
// keep filling; s_tready drops only once all five stages hold a result.
// Reset (aresetn low, synchronous) empties the pipeline and sets both
// registers to 230.
`timescale 1ns / 1ps

`include "id_hash_hue_to_rgb_core_assert.svh"

module id_hash_hue_to_rgb_core
    import idhr_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [HASH_BITS-1:0]                 s_tdata,  // player_id
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [8*((3*CHANNEL_BITS+7)/8)-1:0]  m_tdata,  // red, green, blue, zero pad
    input  logic                                 cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]             cfg_addr,
    input  logic [CHANNEL_BITS-1:0]              cfg_wdata
);

    localparam int CB    = CHANNEL_BITS;
    localparam int PW    = 2 * CB;
    localparam int OUT_W = 8 * ((3 * CB + 7) / 8);
    localparam logic [CB-1:0] CFG_RESET = CB'(CFG_RESET_VAL);

    logic [CB-1:0] sat_reg;
    logic [CB-1:0] bri_reg;

    logic               hue_valid;
    logic               hue_ready;
    sector_t            hue_sector;
    logic [FRAC_BITS:0] hue_t;
    logic [PW-1:0]      hue_c;
    logic [PW-1:0]      hue_m;

    logic               ramp_valid;
    logic               ramp_ready;
    sector_t            ramp_sector;
    logic [PW-1:0]      ramp_x;
    logic [PW-1:0]      ramp_c;
    logic [PW-1:0]      ramp_m;

    logic [CB-1:0]      red;
    logic [CB-1:0]      green;
    logic [CB-1:0]      blue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= CFG_RESET;
            bri_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SATURATION: sat_reg <= cfg_wdata;
                REG_BRIGHTNESS: bri_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    idhr_hue #(.CB(CB)) u_hue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .player_id  (s_tdata),
        .saturation (sat_reg),
        .brightness (bri_reg),
        .out_valid  (hue_valid),
        .out_ready  (hue_ready),
        .sector     (hue_sector),
        .ramp_t     (hue_t),
        .chroma     (hue_c),
        .offset     (hue_m)
    );

    idhr_ramp #(.CB(CB)) u_ramp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (hue_valid),
        .in_ready   (hue_ready),
        .in_sector  (hue_sector),
        .ramp_t     (hue_t),
        .in_chroma  (hue_c),
        .in_offset  (hue_m),
        .out_valid  (ramp_valid),
        .out_ready  (ramp_ready),
        .out_sector (ramp_sector),
        .ramp_x     (ramp_x),
        .out_chroma (ramp_c),
        .out_offset (ramp_m)
    );

    idhr_chan #(.CB(CB)) u_chan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .sector    (ramp_sector),
        .ramp_x    (ramp_x),
        .chroma    (ramp_c),
        .offset    (ramp_m),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = OUT_W'({blue, green, red});

    `IDHR_ASSERT(a_stall_only_from_full, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready && hue_valid && ramp_valid), "input stalled without a full pipeline")
    `IDHR_ASSERT(a_ramp_stall_chain, aclk, aresetn, !ramp_ready |-> (m_tvalid && !m_tready), "ramp stage stalled while output free")
    `IDHR_ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> (!m_tvalid && !hue_valid && !ramp_valid), "pipeline not empty after reset")

endmodule

[design/idhr_hue.sv]
// Hash and sector stages: Fibonacci hash, chroma, offset, sector and ramp fraction.
`timescale 1ns / 1ps

module idhr_hue
    import idhr_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [HASH_BITS-1:0]  player_id,
    input  logic [CB-1:0]         saturation,
    input  logic [CB-1:0]         brightness,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sector_t               sector,
    output logic [FRAC_BITS:0]    ramp_t,
    output logic [2*CB-1:0]       chroma,
    output logic [2*CB-1:0]       offset
);

    localparam int PW = 2 * CB;
    localparam int PB = HUE_BITS + SECT_BITS;
    localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 va_reg;
    logic [HASH_BITS-1:0] hash_reg;
    logic [PW-1:0]        ca_reg;
    logic [CB-1:0]        bria_reg;

    logic                 vb_reg;
    sector_t              sect_reg;
    logic [FRAC_BITS:0]   t_reg;
    logic [PW-1:0]        cb_reg;
    logic [PW-1:0]        mb_reg;

    logic                 adv_a;
    logic                 adv_b;
    logic [HASH_BITS-1:0] hash_next;
    logic [PW-1:0]        c_next;
    logic [HUE_BITS-1:0]  hue;
    logic [PB-1:0]        p;
    logic [FRAC_BITS-1:0] f;
    logic [FRAC_BITS:0]   t_next;
    logic [PW-1:0]        m_next;

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    assign hash_next = player_id * HASH_MUL;
    assign c_next    = PW'(saturation) * PW'(brightness);

    assign hue    = hash_reg[HASH_BITS-1 -: HUE_BITS];
    assign p      = (PB'(hue) << 2) + (PB'(hue) << 1);
    assign f      = p[FRAC_BITS-1:0];
    assign t_next = p[FRAC_BITS] ? (T_ONE - {1'b0, f}) : {1'b0, f};
    assign m_next = (PW'(bria_reg) << CB) - PW'(bria_reg) - ca_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                va_reg <= in_valid;
            end
            if (adv_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a && in_valid) begin
            hash_reg <= hash_next;
            ca_reg   <= c_next;
            bria_reg <= brightness;
        end
        if (adv_b && va_reg) begin
            sect_reg <= sector_t'(p[PB-1:FRAC_BITS]);
            t_reg    <= t_next;
            cb_reg   <= ca_reg;
            mb_reg   <= m_next;
        end
    end

    assign out_valid = vb_reg;
    assign sector    = sect_reg;
    assign ramp_t    = t_reg;
    assign chroma    = cb_reg;
    assign offset    = mb_reg;

endmodule

[design/idhr_ramp.sv]
// Ramp stage: rounded product of chroma and ramp fraction.
`timescale 1ns / 1ps

module idhr_ramp
    import idhr_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sector_t             in_sector,
    input  logic [FRAC_BITS:0]  ramp_t,
    input  logic [2*CB-1:0]     in_chroma,
    input  logic [2*CB-1:0]     in_offset,
    output logic                out_valid,
    input  logic                out_ready,
    output sector_t             out_sector,
    output logic [2*CB-1:0]     ramp_x,
    output logic [2*CB-1:0]     out_chroma,
    output logic [2*CB-1:0]     out_offset
);

    localparam int PW = 2 * CB;
    localparam int RW = PW + FRAC_BITS + 1;
    localparam logic [RW-1:0] ROUND = RW'(1) << (FRAC_BITS - 1);

    logic          v_reg;
    sector_t       sect_reg;
    logic [PW-1:0] x_reg;
    logic [PW-1:0] c_reg;
    logic [PW-1:0] m_reg;

    logic          adv;
    logic [RW-1:0] prod;

    assign adv      = !v_reg || out_ready;
    assign in_ready = adv;
    assign prod     = RW'(in_chroma) * RW'(ramp_t) + ROUND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            sect_reg <= in_sector;
            x_reg    <= prod[FRAC_BITS +: PW];
            c_reg    <= in_chroma;
            m_reg    <= in_offset;
        end
    end

    assign out_valid  = v_reg;
    assign out_sector = sect_reg;
    assign ramp_x     = x_reg;
    assign out_chroma = c_reg;
    assign out_offset = m_reg;

endmodule

[design/idhr_chan.sv]
// Channel stages: sector mux, offset add and rounded scale back to channel codes.
`timescale 1ns / 1ps

module idhr_chan
    import idhr_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sector_t          sector,
    input  logic [2*CB-1:0]  ramp_x,
    input  logic [2*CB-1:0]  chroma,
    input  logic [2*CB-1:0]  offset,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CB-1:0]    red,
    output logic [CB-1:0]    green,
    output logic [CB-1:0]    blue
);

    localparam int PW = 2 * CB;
    localparam int QW = PW + 1;
    localparam int SW = QW + 1;
    localparam int EW = SW - CB;
    localparam logic [SW-1:0] CMAX = SW'((1 << CB) - 1);
    localparam logic [QW-1:0] HALF = QW'(((1 << CB) - 1) / 2);

    logic          va_reg;
    logic [QW-1:0] q_reg [3];
    logic          vb_reg;
    logic [CB-1:0] ch_reg [3];

    logic          adv_a;
    logic          adv_b;
    logic [PW-1:0] comp [3];
    logic [QW-1:0] q_next [3];
    logic [CB-1:0] ch_next [3];
    logic [SW-1:0] s    [3];
    logic [EW-1:0] e    [3];
    logic [SW-1:0] rem  [3];
    logic [EW-1:0] quo  [3];

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    always_comb begin
        comp[0] = '0;
        comp[1] = '0;
        comp[2] = '0;
        case (sector)
            SECT_RED_TO_YEL: begin
                comp[0] = chroma;
                comp[1] = ramp_x;
            end
            SECT_YEL_TO_GRN: begin
                comp[0] = ramp_x;
                comp[1] = chroma;
            end
            SECT_GRN_TO_CYN: begin
                comp[1] = chroma;
                comp[2] = ramp_x;
            end
            SECT_CYN_TO_BLU: begin
                comp[1] = ramp_x;
                comp[2] = chroma;
            end
            SECT_BLU_TO_MAG: begin
                comp[0] = ramp_x;
                comp[2] = chroma;
            end
            default: begin
                comp[0] = chroma;
                comp[2] = ramp_x;
            end
        endcase
    end

    // Divide by 2^CB-1: estimate low by at most one, then one correction.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_next[i]  = QW'(comp[i]) + QW'(offset) + HALF;
            s[i]       = SW'(q_reg[i]) + SW'(q_reg[i] >> CB);
            e[i]       = s[i][SW-1:CB];
            rem[i]     = SW'(q_reg[i]) - ((SW'(e[i]) << CB) - SW'(e[i]));
            quo[i]     = (rem[i] >= CMAX) ? (e[i] + EW'(1)) : e[i];
            ch_next[i] = quo[i][CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                va_reg <= in_valid;
            end
            if (adv_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a && in_valid) begin
            q_reg <= q_next;
        end
        if (adv_b && va_reg) begin
            ch_reg <= ch_next;
        end
    end

    assign out_valid = vb_reg;
    assign red       = ch_reg[0];
    assign green     = ch_reg[1];
    assign blue      = ch_reg[2];

endmodule
